### rtl/bsse_pkg.sv
// shared types, constants and saturation helpers for the b-spline surface evaluator
// used by every rtl file of the block; depends on nothing
`default_nettype none

package bsse_pkg;

    localparam int MAX_DEGREE = 3;
    localparam int MAX_CTRL   = 32;
    localparam int MAX_KNOTS  = 64;
    localparam int FRAC_BITS  = 16;

    localparam int DEG_W     = 2;
    localparam int CC_W      = 6;
    localparam int KC_W      = 7;
    localparam int IDXA_W    = 6;
    localparam int IDXB_W    = 5;
    localparam int KNOT_W    = 17;
    localparam int CRD_W     = 32;
    localparam int SPAN_W    = 5;
    localparam int KA_W      = $clog2(MAX_KNOTS);
    localparam int RC_W      = $clog2(MAX_CTRL);
    localparam int GA_W      = 2 * RC_W;
    localparam int NB_N      = MAX_DEGREE + 1;
    localparam int NB_IW     = $clog2(NB_N);
    localparam int DIF_W     = KNOT_W + 1;
    localparam int DEN_W     = KNOT_W + 2;
    localparam int NUM_W     = DIF_W + CRD_W;
    localparam int QUO_W     = NUM_W + 1;
    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;

    typedef enum logic [1:0] {
        ACT_LOAD_U  = 2'd0,
        ACT_LOAD_V  = 2'd1,
        ACT_LOAD_PT = 2'd2,
        ACT_EVAL    = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE_U     = 3'd0,
        CFG_DEGREE_V     = 3'd1,
        CFG_CTRL_COUNT_U = 3'd2,
        CFG_CTRL_COUNT_V = 3'd3,
        CFG_KNOT_COUNT_U = 3'd4,
        CFG_KNOT_COUNT_V = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        t_action                  action;
        logic [IDXA_W-1:0]        index_a;
        logic [IDXB_W-1:0]        index_b;
        logic [KNOT_W-1:0]        knot_value;
        logic signed [CRD_W-1:0]  coord_x;
        logic signed [CRD_W-1:0]  coord_y;
        logic signed [CRD_W-1:0]  coord_z;
        logic [KNOT_W-1:0]        param_u;
        logic [KNOT_W-1:0]        param_v;
    } t_in_word;

    typedef struct packed {
        logic signed [CRD_W-1:0]  point_x;
        logic signed [CRD_W-1:0]  point_y;
        logic signed [CRD_W-1:0]  point_z;
        logic [SPAN_W-1:0]        span_u;
        logic [SPAN_W-1:0]        span_v;
    } t_out_word;

    // decoded command as held in the queue
    typedef struct packed {
        t_action                  act;
        logic                     pt_ok;
        logic [IDXA_W-1:0]        index_a;
        logic [IDXB_W-1:0]        index_b;
        logic [KNOT_W-1:0]        knot_value;
        logic [3*CRD_W-1:0]       coords;
        logic [KNOT_W-1:0]        param_u;
        logic [KNOT_W-1:0]        param_v;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctl;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH_ADDR, S_SRCH_CMP, S_SPAN, S_KL_ADDR, S_KR_ADDR, S_KR_CAP,
        S_MUL, S_DIV_GO, S_DIV_WAIT, S_UPD, S_DIR_DONE, S_ROW, S_G_ADDR, S_G_MUL,
        S_G_ADD, S_O_SAT, S_O_MUL, S_O_ADD, S_FIN
    } t_state;

    function automatic logic signed [CRD_W-1:0] f_sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[CRD_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] f_sat_add(input logic signed [ACC_W-1:0] a,
                                                          input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/bsse_front.sv
// front end: accepts input words and hands decoded commands to the back end
// depends on bsse_pkg and bsse_fifo
`default_nettype none

module bsse_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  bsse_pkg::t_in_word  i_in_word,
    input  bsse_pkg::t_q_ctl    i_q_ctl,
    output bsse_pkg::t_q_ctl    o_q_ctl,
    output bsse_pkg::t_cmd      o_cmd
);
    bsse_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_ctl    (i_q_ctl),
        .o_q_ctl    (o_q_ctl),
        .o_cmd      (o_cmd)
    );

endmodule

`default_nettype wire

### rtl/bsse_div.sv
// iterative signed divider, one quotient bit a cycle, truncating toward zero
// depends on bsse_pkg
`default_nettype none

module bsse_div (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire signed [bsse_pkg::NUM_W-1:0]      i_num,
    input  wire signed [bsse_pkg::DEN_W-1:0]      i_den,
    output logic                                  o_done,
    output logic signed [bsse_pkg::QUO_W-1:0]     o_quo
);
    localparam int CNT_W = $clog2(bsse_pkg::NUM_W + 1);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_done;
    logic                          r_neg;
    logic [bsse_pkg::DEN_W-1:0]    r_rem;
    logic [bsse_pkg::DEN_W-1:0]    r_dmag;
    logic [bsse_pkg::NUM_W-1:0]    r_quo;
    logic [bsse_pkg::DEN_W:0]      shifted;
    logic                          ge;

    assign shifted = {r_rem, r_quo[bsse_pkg::NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(bsse_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_neg  <= i_num[bsse_pkg::NUM_W-1] ^ i_den[bsse_pkg::DEN_W-1];
            r_quo  <= i_num[bsse_pkg::NUM_W-1] ? bsse_pkg::NUM_W'(-i_num)
                                               : bsse_pkg::NUM_W'(i_num);
            r_dmag <= i_den[bsse_pkg::DEN_W-1] ? bsse_pkg::DEN_W'(-i_den)
                                               : bsse_pkg::DEN_W'(i_den);
        end else if (r_busy) begin
            r_rem <= ge ? bsse_pkg::DEN_W'(shifted - {1'b0, r_dmag})
                        : shifted[bsse_pkg::DEN_W-1:0];
            r_quo <= {r_quo[bsse_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

`default_nettype wire

### rtl/bsse_core.sv
// back end: executes loads and evaluations, holds knot and grid memories and the result register
// depends on bsse_pkg and bsse_div
`default_nettype none

module bsse_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [bsse_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [bsse_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    input  bsse_pkg::t_q_ctl                      i_q_ctl,
    output bsse_pkg::t_q_ctl                      o_q_ctl,
    input  bsse_pkg::t_cmd                        i_cmd,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output bsse_pkg::t_out_word                   o_out_word
);
    localparam int KW  = bsse_pkg::KNOT_W;
    localparam int CW  = bsse_pkg::CRD_W;
    localparam int AW  = bsse_pkg::ACC_W;
    localparam int NI  = bsse_pkg::NB_IW;
    localparam logic signed [CW-1:0] ONE = CW'(1) <<< bsse_pkg::FRAC_BITS;

    // configuration
    logic [bsse_pkg::DEG_W-1:0] r_deg_u, r_deg_v;
    logic [bsse_pkg::CC_W-1:0]  r_cc_u, r_cc_v;
    logic [bsse_pkg::KC_W-1:0]  r_kc_u, r_kc_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_u <= 2'd3;
            r_deg_v <= 2'd3;
            r_cc_u  <= 6'd32;
            r_cc_v  <= 6'd32;
            r_kc_u  <= 7'd36;
            r_kc_v  <= 7'd36;
        end else if (i_cfg_we) begin
            unique case (bsse_pkg::t_cfg_reg'(i_cfg_index))
                bsse_pkg::CFG_DEGREE_U:     r_deg_u <= i_cfg_data[bsse_pkg::DEG_W-1:0];
                bsse_pkg::CFG_DEGREE_V:     r_deg_v <= i_cfg_data[bsse_pkg::DEG_W-1:0];
                bsse_pkg::CFG_CTRL_COUNT_U: r_cc_u  <= i_cfg_data[bsse_pkg::CC_W-1:0];
                bsse_pkg::CFG_CTRL_COUNT_V: r_cc_v  <= i_cfg_data[bsse_pkg::CC_W-1:0];
                bsse_pkg::CFG_KNOT_COUNT_U: r_kc_u  <= i_cfg_data[bsse_pkg::KC_W-1:0];
                bsse_pkg::CFG_KNOT_COUNT_V: r_kc_v  <= i_cfg_data[bsse_pkg::KC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective (clamped) settings
    logic [bsse_pkg::CC_W-1:0] cu, cv;
    logic [bsse_pkg::KC_W-1:0] nu_k, nv_k;
    assign cu   = (r_cc_u == '0) ? 6'd1 : ((r_cc_u > 6'd32) ? 6'd32 : r_cc_u);
    assign cv   = (r_cc_v == '0) ? 6'd1 : ((r_cc_v > 6'd32) ? 6'd32 : r_cc_v);
    assign nu_k = (r_kc_u > 7'd64) ? 7'd64 : r_kc_u;
    assign nv_k = (r_kc_v > 7'd64) ? 7'd64 : r_kc_v;

    bsse_pkg::t_state r_state, n_state;

    logic                        r_dir;
    logic [bsse_pkg::KC_W-1:0]   r_cnt;
    logic [bsse_pkg::KC_W-1:0]   r_below;
    logic [KW-1:0]               r_t, r_pv;
    logic [bsse_pkg::SPAN_W-1:0] r_span, r_su, r_sv;
    logic [NI-1:0]               r_j, r_r, r_i, r_jj;
    logic signed [bsse_pkg::DIF_W-1:0] r_lf [bsse_pkg::NB_N];
    logic signed [bsse_pkg::DIF_W-1:0] r_rt [bsse_pkg::NB_N];
    logic signed [CW-1:0]        r_nb [bsse_pkg::NB_N];
    logic signed [CW-1:0]        r_nu [bsse_pkg::NB_N];
    logic signed [CW-1:0]        r_nv [bsse_pkg::NB_N];
    logic signed [CW-1:0]        r_saved;
    logic signed [bsse_pkg::DEN_W-1:0] r_den;
    logic signed [bsse_pkg::NUM_W-1:0] r_pa, r_pb;
    logic                        r_zero;
    logic signed [AW-1:0]        r_inner [3];
    logic signed [AW-1:0]        r_outer [3];
    logic signed [AW-1:0]        r_prod  [3];
    logic signed [CW-1:0]        r_tc    [3];
    logic [3*CW-1:0]             r_gdat;
    logic [KW-1:0]               r_kdat_u, r_kdat_v;
    logic                        r_out_valid;
    bsse_pkg::t_out_word         r_out_word;

    logic [bsse_pkg::DEG_W-1:0]  deg_d;
    logic [bsse_pkg::CC_W-1:0]   cc_d;
    logic [bsse_pkg::KC_W-1:0]   n_d;
    logic [KW-1:0]               kdat;
    assign deg_d = r_dir ? r_deg_v : r_deg_u;
    assign cc_d  = r_dir ? cv : cu;
    assign n_d   = r_dir ? nv_k : nu_k;
    assign kdat  = r_dir ? r_kdat_v : r_kdat_u;

    // memories
    logic [KW-1:0]    knots_u [bsse_pkg::MAX_KNOTS];
    logic [KW-1:0]    knots_v [bsse_pkg::MAX_KNOTS];
    logic [3*CW-1:0]  grid    [bsse_pkg::MAX_CTRL * bsse_pkg::MAX_CTRL];

    logic                         we_ku, we_kv, we_g;
    logic [bsse_pkg::KA_W-1:0]    k_raddr;
    logic [bsse_pkg::GA_W-1:0]    g_raddr, g_waddr;
    logic                         div_start, fin_load, slot_free, pop;

    assign g_waddr = {i_cmd.index_a[bsse_pkg::RC_W-1:0], i_cmd.index_b[bsse_pkg::RC_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (we_ku) begin
            knots_u[i_cmd.index_a[bsse_pkg::KA_W-1:0]] <= i_cmd.knot_value;
        end
        r_kdat_u <= knots_u[k_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_kv) begin
            knots_v[i_cmd.index_a[bsse_pkg::KA_W-1:0]] <= i_cmd.knot_value;
        end
        r_kdat_v <= knots_v[k_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_g) begin
            grid[g_waddr] <= i_cmd.coords;
        end
        r_gdat <= grid[g_raddr];
    end

    // dividers for the two recurrence terms
    logic                              done_a, done_b;
    logic signed [bsse_pkg::QUO_W-1:0] quo_a, quo_b;

    bsse_div u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pa),
        .i_den   (r_den),
        .o_done  (done_a),
        .o_quo   (quo_a)
    );

    bsse_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pb),
        .i_den   (r_den),
        .o_done  (done_b),
        .o_quo   (quo_b)
    );

    // span clamp
    logic signed [7:0] s_raw, s_lo;
    logic [bsse_pkg::SPAN_W-1:0] span_n;
    always_comb begin
        s_raw  = $signed({1'b0, r_below}) - 8'sd1;
        s_lo   = (s_raw < $signed({6'b0, deg_d})) ? $signed({6'b0, deg_d}) : s_raw;
        if (s_lo > $signed({2'b0, cc_d}) - 8'sd1) begin
            s_lo = $signed({2'b0, cc_d}) - 8'sd1;
        end
        span_n = s_lo[bsse_pkg::SPAN_W-1:0];
    end

    // row and column of the grid access, clamped into the grid
    logic signed [7:0] row_s, col_s;
    logic [bsse_pkg::RC_W-1:0] row, col;
    always_comb begin
        row_s = $signed({3'b0, r_su}) - $signed({6'b0, r_deg_u}) + $signed({6'b0, r_i});
        col_s = $signed({3'b0, r_sv}) - $signed({6'b0, r_deg_v}) + $signed({6'b0, r_jj});
        if (row_s < 8'sd0) begin
            row_s = 8'sd0;
        end
        if (row_s > $signed({2'b0, cu}) - 8'sd1) begin
            row_s = $signed({2'b0, cu}) - 8'sd1;
        end
        if (col_s < 8'sd0) begin
            col_s = 8'sd0;
        end
        if (col_s > $signed({2'b0, cv}) - 8'sd1) begin
            col_s = $signed({2'b0, cv}) - 8'sd1;
        end
        row = row_s[bsse_pkg::RC_W-1:0];
        col = col_s[bsse_pkg::RC_W-1:0];
    end

    assign slot_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsse_pkg::S_IDLE: begin
                if (i_q_ctl.valid && i_cmd.act == bsse_pkg::ACT_EVAL) begin
                    n_state = bsse_pkg::S_SRCH_ADDR;
                end
            end
            bsse_pkg::S_SRCH_ADDR: begin
                n_state = (r_cnt == n_d) ? bsse_pkg::S_SPAN : bsse_pkg::S_SRCH_CMP;
            end
            bsse_pkg::S_SRCH_CMP: n_state = bsse_pkg::S_SRCH_ADDR;
            bsse_pkg::S_SPAN: begin
                n_state = (deg_d == '0) ? bsse_pkg::S_DIR_DONE : bsse_pkg::S_KL_ADDR;
            end
            bsse_pkg::S_KL_ADDR: n_state = bsse_pkg::S_KR_ADDR;
            bsse_pkg::S_KR_ADDR: n_state = bsse_pkg::S_KR_CAP;
            bsse_pkg::S_KR_CAP:  n_state = bsse_pkg::S_MUL;
            bsse_pkg::S_MUL:     n_state = bsse_pkg::S_DIV_GO;
            bsse_pkg::S_DIV_GO: begin
                n_state = (r_den == '0) ? bsse_pkg::S_UPD : bsse_pkg::S_DIV_WAIT;
            end
            bsse_pkg::S_DIV_WAIT: begin
                if (done_a && done_b) begin
                    n_state = bsse_pkg::S_UPD;
                end
            end
            bsse_pkg::S_UPD: begin
                if (r_r == r_j - NI'(1)) begin
                    n_state = (r_j == NI'(deg_d)) ? bsse_pkg::S_DIR_DONE
                                                  : bsse_pkg::S_KL_ADDR;
                end else begin
                    n_state = bsse_pkg::S_MUL;
                end
            end
            bsse_pkg::S_DIR_DONE: begin
                n_state = r_dir ? bsse_pkg::S_ROW : bsse_pkg::S_SRCH_ADDR;
            end
            bsse_pkg::S_ROW:   n_state = bsse_pkg::S_G_ADDR;
            bsse_pkg::S_G_ADDR: n_state = bsse_pkg::S_G_MUL;
            bsse_pkg::S_G_MUL: n_state = bsse_pkg::S_G_ADD;
            bsse_pkg::S_G_ADD: begin
                n_state = (r_jj == NI'(r_deg_v)) ? bsse_pkg::S_O_SAT : bsse_pkg::S_G_ADDR;
            end
            bsse_pkg::S_O_SAT: n_state = bsse_pkg::S_O_MUL;
            bsse_pkg::S_O_MUL: n_state = bsse_pkg::S_O_ADD;
            bsse_pkg::S_O_ADD: begin
                n_state = (r_i == NI'(r_deg_u)) ? bsse_pkg::S_FIN : bsse_pkg::S_ROW;
            end
            bsse_pkg::S_FIN: begin
                if (slot_free) begin
                    n_state = bsse_pkg::S_IDLE;
                end
            end
            default: n_state = bsse_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop       = 1'b0;
        we_ku     = 1'b0;
        we_kv     = 1'b0;
        we_g      = 1'b0;
        k_raddr   = r_cnt[bsse_pkg::KA_W-1:0];
        g_raddr   = {row, col};
        div_start = 1'b0;
        fin_load  = 1'b0;
        unique case (r_state)
            bsse_pkg::S_IDLE: begin
                pop   = i_q_ctl.valid;
                we_ku = i_q_ctl.valid && i_cmd.act == bsse_pkg::ACT_LOAD_U;
                we_kv = i_q_ctl.valid && i_cmd.act == bsse_pkg::ACT_LOAD_V;
                we_g  = i_q_ctl.valid && i_cmd.act == bsse_pkg::ACT_LOAD_PT && i_cmd.pt_ok;
            end
            // knot indices wrap around the store
            bsse_pkg::S_KL_ADDR: begin
                k_raddr = bsse_pkg::KA_W'({1'b0, r_span} - {3'b0, r_j} + 6'd1);
            end
            bsse_pkg::S_KR_ADDR: begin
                k_raddr = bsse_pkg::KA_W'({1'b0, r_span} + {3'b0, r_j});
            end
            bsse_pkg::S_DIV_GO: div_start = (r_den != '0);
            bsse_pkg::S_FIN:    fin_load  = slot_free;
            default: ;
        endcase
    end

    assign o_q_ctl.valid = 1'b0;
    assign o_q_ctl.pop   = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsse_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    logic signed [AW-1:0] sum_a;
    assign sum_a = AW'(r_saved) + (r_zero ? AW'(0) : AW'(quo_a));

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bsse_pkg::S_IDLE: begin
                r_dir   <= 1'b0;
                r_cnt   <= '0;
                r_below <= '0;
                r_t     <= i_cmd.param_u;
                r_pv    <= i_cmd.param_v;
            end
            bsse_pkg::S_SRCH_CMP: begin
                if (kdat < r_t) begin
                    r_below <= r_below + bsse_pkg::KC_W'(1);
                end
                r_cnt <= r_cnt + bsse_pkg::KC_W'(1);
            end
            bsse_pkg::S_SPAN: begin
                r_span  <= span_n;
                r_nb[0] <= ONE;
                r_j     <= NI'(1);
            end
            bsse_pkg::S_KR_ADDR: begin
                r_lf[r_j] <= $signed({1'b0, r_t}) - $signed({1'b0, kdat});
            end
            bsse_pkg::S_KR_CAP: begin
                r_rt[r_j] <= $signed({1'b0, kdat}) - $signed({1'b0, r_t});
                r_r       <= '0;
                r_saved   <= '0;
            end
            bsse_pkg::S_MUL: begin
                r_den <= bsse_pkg::DEN_W'(r_rt[r_r + NI'(1)]) + bsse_pkg::DEN_W'(r_lf[r_j - r_r]);
                r_pa  <= r_rt[r_r + NI'(1)] * r_nb[r_r];
                r_pb  <= r_lf[r_j - r_r] * r_nb[r_r];
            end
            bsse_pkg::S_DIV_GO: r_zero <= (r_den == '0);
            bsse_pkg::S_UPD: begin
                r_nb[r_r] <= bsse_pkg::f_sat32(sum_a);
                r_saved   <= r_zero ? '0 : bsse_pkg::f_sat32(AW'(quo_b));
                if (r_r == r_j - NI'(1)) begin
                    r_nb[r_j] <= r_zero ? '0 : bsse_pkg::f_sat32(AW'(quo_b));
                    r_j       <= r_j + NI'(1);
                end else begin
                    r_r <= r_r + NI'(1);
                end
            end
            bsse_pkg::S_DIR_DONE: begin
                r_cnt   <= '0;
                r_below <= '0;
                r_dir   <= 1'b1;
                r_t     <= r_pv;
                if (r_dir) begin
                    r_nv <= r_nb;
                    r_sv <= r_span;
                end else begin
                    r_nu <= r_nb;
                    r_su <= r_span;
                end
                r_i <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_outer[c] <= '0;
                end
            end
            bsse_pkg::S_ROW: begin
                r_jj <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_inner[c] <= '0;
                end
            end
            bsse_pkg::S_G_MUL: begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[c] <= r_nv[r_jj] * $signed(r_gdat[(2-c)*CW +: CW]);
                end
            end
            bsse_pkg::S_G_ADD: begin
                for (int c = 0; c < 3; c++) begin
                    r_inner[c] <= bsse_pkg::f_sat_add(r_inner[c], r_prod[c]);
                end
                r_jj <= r_jj + NI'(1);
            end
            bsse_pkg::S_O_SAT: begin
                for (int c = 0; c < 3; c++) begin
                    r_tc[c] <= bsse_pkg::f_sat32(r_inner[c] >>> bsse_pkg::FRAC_BITS);
                end
            end
            bsse_pkg::S_O_MUL: begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[c] <= r_nu[r_i] * r_tc[c];
                end
            end
            bsse_pkg::S_O_ADD: begin
                for (int c = 0; c < 3; c++) begin
                    r_outer[c] <= bsse_pkg::f_sat_add(r_outer[c], r_prod[c]);
                end
                r_i <= r_i + NI'(1);
            end
            bsse_pkg::S_FIN: begin
                if (fin_load) begin
                    r_out_word.point_x <= bsse_pkg::f_sat32(r_outer[0] >>> bsse_pkg::FRAC_BITS);
                    r_out_word.point_y <= bsse_pkg::f_sat32(r_outer[1] >>> bsse_pkg::FRAC_BITS);
                    r_out_word.point_z <= bsse_pkg::f_sat32(r_outer[2] >>> bsse_pkg::FRAC_BITS);
                    r_out_word.span_u  <= r_su;
                    r_out_word.span_v  <= r_sv;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

### rtl/bspline_surface_point_eval.sv
// B-spline surface point evaluator. Each input word is one action: a u or v knot load, a
// control point load or an evaluation. The back end writes loads straight from its idle
// state. An evaluation runs, per direction, a span search (one read of the knot memory per
// compare) and a hand-over, then per basis order the knot reads and per recurrence term a
// division by the 50-step divider (skipped when the denominator is zero), then a weighted
// sum over the grid, point by point and row by row, and a finish step that waits for the
// output register. A two-entry queue takes words while the back end works; the result
// waits in an output register, so a finished evaluation does not hold up later loads in
// the queue.
// depends on bsse_pkg, bsse_front, bsse_core
`default_nettype none

module bspline_surface_point_eval (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [bsse_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [bsse_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  bsse_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output bsse_pkg::t_out_word                o_out_word
);
    bsse_pkg::t_cmd   cmd;
    bsse_pkg::t_q_ctl q_to_core, q_from_core;

    bsse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_ctl    (q_from_core),
        .o_q_ctl    (q_to_core),
        .o_cmd      (cmd)
    );

    bsse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_ctl     (q_to_core),
        .o_q_ctl     (q_from_core),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

### rtl/bsse_fifo.sv
// front end: decodes input words and holds them in a two-entry queue for the back end
// depends on bsse_pkg
`default_nettype none

module bsse_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  bsse_pkg::t_in_word  i_in_word,
    input  bsse_pkg::t_q_ctl    i_q_ctl,
    output bsse_pkg::t_q_ctl    o_q_ctl,
    output bsse_pkg::t_cmd      o_cmd
);
    bsse_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    bsse_pkg::t_cmd dec;
    logic           push, pop;

    // classify: a point load outside the grid is dropped by the back end
    always_comb begin
        dec.act        = i_in_word.action;
        dec.pt_ok      = (i_in_word.index_a < bsse_pkg::IDXA_W'(bsse_pkg::MAX_CTRL));
        dec.index_a    = i_in_word.index_a;
        dec.index_b    = i_in_word.index_b;
        dec.knot_value = i_in_word.knot_value;
        dec.coords     = {i_in_word.coord_x, i_in_word.coord_y, i_in_word.coord_z};
        dec.param_u    = i_in_word.param_u;
        dec.param_v    = i_in_word.param_v;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_ctl.pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= dec;
        end
    end

    assign o_q_ctl.valid = (r_cnt != 2'd0);
    assign o_q_ctl.pop   = 1'b0;
    assign o_cmd         = r_mem[r_rp];

endmodule

`default_nettype wire

### rtl/bsse_chk.sv
// port-level checker for the surface evaluator and its bind to the top level
// depends on bsse_pkg
`default_nettype none

module bsse_chk (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_in_stall,
    input wire                            o_out_valid,
    input wire                            i_out_stall,
    input bsse_pkg::t_out_word            o_out_word
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("result word changed while stalled");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind bspline_surface_point_eval bsse_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
